@@ hw/rtl/ihd_pkg.sv @@
// Shared operation codes, status codes, field widths and defaults of the interrupt dispatcher.
package ihd_pkg;

  localparam int OP_W     = 3;
  localparam int LINE_W   = 5;
  localparam int SLOT_W   = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  localparam int LINES_DEF    = 32;
  localparam int PER_LINE_DEF = 2;

  // The enable mask comes out of reset with every line enabled.
  localparam logic [WORD_W-1:0] MASK_RESET = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER    = 3'd0,
    OP_UNREGISTER  = 3'd1,
    OP_SET_PENDING = 3'd2,
    OP_WRITE_MASK  = 3'd3,
    OP_READ_MASK   = 3'd4,
    OP_DISPATCH    = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

endpackage

@@ hw/rtl/interrupt_handler_dispatch_top.sv @@
// Interrupt controller with enable mask, pending word and a per-line handler list in memory.
//
//   channel   ports                              handshake
//   --------  ---------------------------------  ----------------------------------------
//   request   start, busy, in_*                  taken on a clock edge with start=1, busy=0
//   result    out_valid, out_*                   shown for exactly one cycle per strobe
//
// Register, set pending, write mask, read mask and unused codes leave busy low: the
// result appears in the cycle after the request and a new request can be taken there.
// An unregister on a line that holds entries keeps busy high while it walks those entries
// in the entry memory, and its result appears when the walk ends.
// Dispatch gives one callback per cycle, bounded by the single read port of the entry
// memory: busy stays high until the last entry is read; an empty dispatch leaves it low.
// Reset is synchronous; it sets the mask to all ones and clears the pending word and the
// handler counts at once. The entry memory has no reset and needs no clearing pass. The
// receiver cannot stall results.
module interrupt_handler_dispatch_top #(
  parameter int LINES    = ihd_pkg::LINES_DEF,
  parameter int PER_LINE = ihd_pkg::PER_LINE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ihd_pkg::OP_W-1:0]      in_op,
  input  logic [ihd_pkg::LINE_W-1:0]    in_line,
  input  logic [ihd_pkg::SLOT_W-1:0]    in_slot,
  input  logic [ihd_pkg::WORD_W-1:0]    in_handler_address,
  input  logic [ihd_pkg::WORD_W-1:0]    in_handler_argument,
  input  logic [ihd_pkg::WORD_W-1:0]    in_mask_value,
  output logic                          out_valid,
  output logic [ihd_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_is_callback,
  output logic [ihd_pkg::WORD_W-1:0]    out_callback_address,
  output logic [ihd_pkg::SLOT_W-1:0]    out_sub_number,
  output logic [ihd_pkg::WORD_W-1:0]    out_callback_argument,
  output logic [ihd_pkg::LINE_W-1:0]    out_fired_line,
  output logic [ihd_pkg::WORD_W-1:0]    out_mask_read,
  output logic                          out_dispatch_request,
  output logic                          out_last
);
  import ihd_pkg::*;

  // Widths that follow from the line count and list depth.
  localparam int SLOTS = LINES * PER_LINE;
  localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CW    = $clog2(PER_LINE + 1);
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // One handler entry as stored in the entry memory.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] address;
    logic [WORD_W-1:0] argument;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_UCMP  = 4'b0010,
    ST_UMOVE = 4'b0100,
    ST_DISP  = 4'b1000
  } state_t;

  // Memory address of entry k of a line.
  function automatic logic [AW-1:0] entry_addr(input logic [LW-1:0] ln, input logic [CW:0] k);
    return AW'(ln) * AW'(PER_LINE) + AW'(k);
  endfunction

  // Index of the lowest set bit, a plain priority encoder.
  function automatic logic [LW-1:0] low_index(input logic [LINES-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = LW'(i);
      end
    end
    return r;
  endfunction

  // Control state.
  state_t             state_r, state_nxt;
  logic [WORD_W-1:0]  mask_r, mask_nxt;
  logic [LINES-1:0]   pend_r, pend_nxt;
  logic [LINES-1:0]   fire_r, fire_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      count_r [LINES];
  logic               out_valid_r, out_valid_nxt;

  // Request fields held while an unregister walks the list.
  logic [LW-1:0]      line_r, line_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;

  // Result payload registers.
  status_t            status_r, status_nxt;
  logic               is_cb_r, is_cb_nxt;
  logic [LINE_W-1:0]  fired_r, fired_nxt;
  logic               req_r, req_nxt;
  logic               last_r, last_nxt;

  // Entry memory ports.
  entry_t             mem [SLOTS];
  entry_t             rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic [AW-1:0]      mem_raddr;

  // Handler count update.
  logic               cnt_we;
  logic [LW-1:0]      cnt_idx;
  logic [CW-1:0]      cnt_val;

  logic               accept;
  logic               line_ok;
  logic [LW-1:0]      line_idx;
  logic [CW-1:0]      cnt_in;
  logic [CW-1:0]      cnt_held;
  logic [LINES-1:0]   fire_now;
  logic [LW-1:0]      cur;
  logic [CW-1:0]      cnt_cur;
  logic [LINES-1:0]   fire_rest;
  logic [CW:0]        k_plus1;
  logic [CW:0]        k_plus2;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign line_ok   = {{(WORD_W - LINE_W){1'b0}}, in_line} < WORD_W'(LINES);
  assign line_idx  = in_line[LW-1:0];
  assign cnt_in    = count_r[line_idx];
  assign cnt_held  = count_r[line_r];
  assign cur       = low_index(fire_r);
  assign cnt_cur   = count_r[cur];
  assign fire_rest = fire_r & (fire_r - LINES'(1));
  assign k_plus1   = {1'b0, k_r} + (CW+1)'(1);
  assign k_plus2   = {1'b0, k_r} + (CW+1)'(2);

  // Lines that a dispatch taken now would serve.
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      fire_now[i] = mask_r[i] && pend_r[i] && (count_r[i] != '0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    pend_nxt      = pend_r;
    fire_nxt      = fire_r;
    k_nxt         = k_r;
    line_nxt      = line_r;
    slot_nxt      = slot_r;
    out_valid_nxt = 1'b0;
    status_nxt    = STATUS_OK;
    is_cb_nxt     = 1'b0;
    fired_nxt     = '0;
    req_nxt       = 1'b0;
    last_nxt      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    cnt_we        = 1'b0;
    cnt_idx       = line_r;
    cnt_val       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b1;
          line_nxt      = line_idx;
          slot_nxt      = in_slot;
          case (op_t'(in_op))
            OP_REGISTER: begin
              if (line_ok) begin
                if (cnt_in >= CW'(PER_LINE)) begin
                  status_nxt = STATUS_FULL;
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = entry_addr(line_idx, {1'b0, cnt_in});
                  mem_wdata = '{slot: in_slot, address: in_handler_address,
                                argument: in_handler_argument};
                  cnt_we    = 1'b1;
                  cnt_idx   = line_idx;
                  cnt_val   = cnt_in + CW'(1);
                end
              end
            end
            OP_UNREGISTER: begin
              if (line_ok) begin
                if (cnt_in == '0) begin
                  status_nxt = STATUS_NOT_FOUND;
                end else begin
                  // Read the head entry; the result comes when the walk ends.
                  out_valid_nxt = 1'b0;
                  last_nxt      = 1'b0;
                  mem_raddr     = entry_addr(line_idx, '0);
                  k_nxt         = '0;
                  state_nxt     = ST_UCMP;
                end
              end
            end
            OP_SET_PENDING: begin
              if (line_ok) begin
                pend_nxt = pend_r | (LINES'(1) << line_idx);
                req_nxt  = 1'b1;
              end
            end
            OP_WRITE_MASK: begin
              mask_nxt = in_mask_value;
              req_nxt  = |(in_mask_value[LINES-1:0] & pend_r);
            end
            OP_DISPATCH: begin
              // With nothing to fire the single empty result is already set up.
              if (fire_now != '0) begin
                out_valid_nxt = 1'b0;
                last_nxt      = 1'b0;
                fire_nxt      = fire_now;
                pend_nxt      = pend_r & ~fire_now;
                k_nxt         = '0;
                state_nxt     = ST_DISP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_UCMP: begin
        // rdata_r holds entry k of the held line.
        if (rdata_r.slot == slot_r) begin
          if (k_plus1 < {1'b0, cnt_held}) begin
            mem_raddr = entry_addr(line_r, k_plus1);
            state_nxt = ST_UMOVE;
          end else begin
            cnt_we        = 1'b1;
            cnt_val       = cnt_held - CW'(1);
            out_valid_nxt = 1'b1;
            last_nxt      = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (k_plus1 < {1'b0, cnt_held}) begin
          k_nxt     = k_plus1[CW-1:0];
          mem_raddr = entry_addr(line_r, k_plus1);
        end else begin
          status_nxt    = STATUS_NOT_FOUND;
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_UMOVE: begin
        // rdata_r holds entry k+1; it moves up into place k.
        mem_we    = 1'b1;
        mem_waddr = entry_addr(line_r, {1'b0, k_r});
        mem_wdata = rdata_r;
        if (k_plus2 < {1'b0, cnt_held}) begin
          k_nxt     = k_plus1[CW-1:0];
          mem_raddr = entry_addr(line_r, k_plus2);
        end else begin
          cnt_we        = 1'b1;
          cnt_val       = cnt_held - CW'(1);
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_DISP: begin
        // One entry read per cycle; its callback is shown in the next cycle.
        mem_raddr     = entry_addr(cur, {1'b0, k_r});
        out_valid_nxt = 1'b1;
        is_cb_nxt     = 1'b1;
        fired_nxt     = LINE_W'(cur);
        if (k_plus1 == {1'b0, cnt_cur}) begin
          fire_nxt = fire_rest;
          k_nxt    = '0;
          last_nxt = (fire_rest == '0);
          if (fire_rest == '0) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          k_nxt = k_plus1[CW-1:0];
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mask_r      <= MASK_RESET;
      pend_r      <= '0;
      fire_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LINES; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      pend_r      <= pend_nxt;
      fire_r      <= fire_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cnt_we) begin
        count_r[cnt_idx] <= cnt_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    line_r   <= line_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    is_cb_r  <= is_cb_nxt;
    fired_r  <= fired_nxt;
    req_r    <= req_nxt;
    last_r   <= last_nxt;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_is_callback       = is_cb_r;
  assign out_callback_address  = is_cb_r ? rdata_r.address  : '0;
  assign out_sub_number        = is_cb_r ? rdata_r.slot     : '0;
  assign out_callback_argument = is_cb_r ? rdata_r.argument : '0;
  assign out_fired_line        = fired_r;
  assign out_mask_read         = mask_r;
  assign out_dispatch_request  = req_r;
  assign out_last              = last_r;

endmodule
